FILE: hw/rtl/dfspt_pkg.sv
`timescale 1ns / 1ps

package dfspt_pkg;

  // Default branch stack depth; the top level may override it.
  localparam int STACK_DEPTH_DEF = 16;

  localparam int ADDR_W  = 16;
  localparam int PORTS_W = 3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PORT  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // One node as it arrives from the scan.
  typedef struct packed {
    logic [ADDR_W-1:0]  node_address;
    logic [PORTS_W-1:0] open_ports;
    logic               scan_start;
  } node_t;

  // One placed node with the address it hangs from.
  typedef struct packed {
    logic [ADDR_W-1:0] child_address;
    logic [ADDR_W-1:0] parent_address;
    status_t           status;
  } place_t;

endpackage

FILE: hw/rtl/dfspt_tree_core.sv
`timescale 1ns / 1ps

module dfspt_tree_core #(
  parameter int STACK_DEPTH = dfspt_pkg::STACK_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  dfspt_pkg::node_t node,
  output dfspt_pkg::place_t place
);
  import dfspt_pkg::*;

  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam int IW = $clog2(STACK_DEPTH);

  logic [ADDR_W-1:0] last_r, last_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [ADDR_W-1:0] stack_r [STACK_DEPTH];

  logic [FW-1:0]      fill_eff;
  logic [FW-1:0]      fill_m1;
  logic [FW:0]        room;
  logic [FW:0]        push_end;
  logic [PORTS_W-1:0] npush;
  logic               overflow;
  logic               can_pop;
  logic [ADDR_W-1:0]  top_addr;
  logic               active;

  // A scan start empties the stack before the node is placed.
  assign fill_eff = node.scan_start ? '0 : fill_r;
  assign fill_m1  = fill_r - FW'(1);
  assign top_addr = stack_r[fill_m1[IW-1:0]];
  assign npush    = (node.open_ports > PORTS_W'(2)) ? node.open_ports - PORTS_W'(2) : '0;
  assign room     = (FW+1)'(STACK_DEPTH) - {1'b0, fill_eff};
  assign overflow = (FW+1)'(npush) > room;
  assign push_end = {1'b0, fill_eff} + (FW+1)'(npush);
  assign can_pop  = !node.scan_start && (fill_r != '0);
  assign active   = (node.open_ports != '0);

  always_comb begin
    last_nxt = last_r;
    fill_nxt = fill_r;
    if (step && active) begin
      last_nxt = node.node_address;
      fill_nxt = fill_eff;
      if (node.open_ports == PORTS_W'(1)) begin
        if (can_pop) begin
          last_nxt = top_addr;
          fill_nxt = fill_m1;
        end
      end else if (npush != '0) begin
        fill_nxt = overflow ? FW'(STACK_DEPTH) : push_end[FW-1:0];
      end
    end
  end

  always_comb begin
    place.child_address  = node.node_address;
    place.parent_address = node.scan_start ? node.node_address : last_r;
    if (!active) begin
      place.status = ST_NO_PORT;
    end else if (overflow) begin
      place.status = ST_OVERFLOW;
    end else begin
      place.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r <= '0;
      fill_r <= '0;
    end else begin
      last_r <= last_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Every slot between the current fill and the end of the new pushes
  // takes the node's address; slots past the top simply are not there.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (step && active && ((FW+1)'(i) >= {1'b0, fill_eff}) &&
          ((FW+1)'(i) < push_end)) begin
        stack_r[i] <= node.node_address;
      end
    end
  end

endmodule

FILE: hw/rtl/dfs_port_count_parent_tracker.sv
// Depth-first bus tree rebuilder: one placed node out for each node in.
// An accepted input transaction waits in the input register and moves into the result register on out_ once it is free.
// Throughput: one transaction per cycle, limited only by out_stall.
// Reset (rst_n low, synchronous): pipeline empties, attachment point is 0,
// branch stack is empty; stack contents themselves are not cleared.
`timescale 1ns / 1ps

module dfs_port_count_parent_tracker #(
  parameter int STACK_DEPTH = dfspt_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_node_address,
  input  logic [2:0]  in_open_ports,
  input  logic        in_scan_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_child_address,
  output logic [15:0] out_parent_address,
  output logic [1:0]  out_status
);
  import dfspt_pkg::*;

  // The input register holds one transaction. It is processed against the
  // tree state as it moves into the result register, so the state update
  // and the result belong to the same clock edge and consecutive nodes see
  // each other's effect without any forwarding.
  logic    s1_valid_r, s1_valid_nxt;
  node_t   s1_node_r;
  logic    out_valid_r, out_valid_nxt;
  place_t  out_place_r;
  place_t  place;
  logic    out_free;
  logic    advance;
  logic    in_take;

  // The result register can take a new value when it is empty or being read.
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  dfspt_tree_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .node  (s1_node_r),
    .place (place)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_node_r.node_address <= in_node_address;
      s1_node_r.open_ports   <= in_open_ports;
      s1_node_r.scan_start   <= in_scan_start;
    end
    if (advance) begin
      out_place_r <= place;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_child_address  = out_place_r.child_address;
  assign out_parent_address = out_place_r.parent_address;
  assign out_status         = out_place_r.status;

endmodule
